// ----- rtl/rsbd_pkg.sv -----
`default_nettype none

package rsbd_pkg;

    localparam int SLOPES   = 63;
    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = 6;
    localparam int CODE_W   = 7;

    localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0]  SLOPES_CNT = CNT_W'(SLOPES);
    localparam logic [CODE_W-1:0] SLOPES_OFS = CODE_W'(SLOPES);

    // sums of one finished segment, handed from accumulation to selection
    typedef struct packed {
        logic [SAMPLE_W-1:0] h_sum;
        logic [SAMPLE_W-1:0] v_sum;
        logic                tile;
    } rsbd_seg_t;

    // magnitude of the wrapped 16-bit difference, 0x8000 stays 0x8000
    function automatic logic [SAMPLE_W-1:0] wrap_abs_diff(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b
    );
        logic [SAMPLE_W-1:0] d;
        d = a - b;
        if (d[SAMPLE_W-1])
        begin
            d = '0 - d;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rsbd_accum.sv -----
`default_nettype none

module rsbd_accum (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    input  wire logic [rsbd_pkg::SAMPLE_W-1:0] h_item,
    input  wire logic [rsbd_pkg::SAMPLE_W-1:0] v_item,
    input  wire logic                          seg_last,
    input  wire logic                          tile_last,
    input  wire logic                          seg_taken,
    output logic                               item_take,
    output logic                               seg_valid,
    output rsbd_pkg::rsbd_seg_t                seg
);
    import rsbd_pkg::*;

    logic [SAMPLE_W-1:0] prev_h_reg, prev_h_next;
    logic [SAMPLE_W-1:0] prev_v_reg, prev_v_next;
    logic [SAMPLE_W-1:0] acc_h_reg, acc_h_next;
    logic [SAMPLE_W-1:0] acc_v_reg, acc_v_next;
    logic                started_reg, started_next;
    logic                seg_valid_reg, seg_valid_next;
    rsbd_seg_t           seg_reg, seg_next;

    logic                seg_end;
    logic                seg_free;
    logic [SAMPLE_W-1:0] sum_h;
    logic [SAMPLE_W-1:0] sum_v;

    assign seg_end  = seg_last || tile_last;
    assign seg_free = !seg_valid_reg || seg_taken;
    // only a segment end needs room downstream
    assign item_take = item_valid && (!seg_end || seg_free);

    assign sum_h = acc_h_reg + (started_reg ? wrap_abs_diff(h_item, prev_h_reg) : '0);
    assign sum_v = acc_v_reg + (started_reg ? wrap_abs_diff(v_item, prev_v_reg) : '0);

    always_comb
    begin
        prev_h_next    = prev_h_reg;
        prev_v_next    = prev_v_reg;
        acc_h_next     = acc_h_reg;
        acc_v_next     = acc_v_reg;
        started_next   = started_reg;
        seg_next       = seg_reg;
        seg_valid_next = seg_valid_reg && !seg_taken;
        if (item_take)
        begin
            prev_h_next = h_item;
            prev_v_next = v_item;
            if (seg_end)
            begin
                acc_h_next     = '0;
                acc_v_next     = '0;
                started_next   = 1'b0;
                seg_next.h_sum = sum_h;
                seg_next.v_sum = sum_v;
                seg_next.tile  = tile_last;
                seg_valid_next = 1'b1;
            end
            else
            begin
                acc_h_next   = sum_h;
                acc_v_next   = sum_v;
                started_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_h_reg    <= '0;
            prev_v_reg    <= '0;
            acc_h_reg     <= '0;
            acc_v_reg     <= '0;
            started_reg   <= 1'b0;
            seg_valid_reg <= 1'b0;
        end
        else
        begin
            prev_h_reg    <= prev_h_next;
            prev_v_reg    <= prev_v_next;
            acc_h_reg     <= acc_h_next;
            acc_v_reg     <= acc_v_next;
            started_reg   <= started_next;
            seg_valid_reg <= seg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg <= seg_next;
    end

    assign seg_valid = seg_valid_reg;
    assign seg       = seg_reg;

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && seg_end |=> !started_reg && acc_h_reg == '0 && acc_v_reg == '0
                                 && seg_valid_reg)
        else $error("segment end did not clear the sums");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid_reg && !seg_taken |-> !(item_take && seg_end))
        else $error("pending segment sums overwritten");

endmodule

`default_nettype wire

// ----- rtl/rsbd_select.sv -----
`default_nettype none

module rsbd_select (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           seg_valid,
    input  wire rsbd_pkg::rsbd_seg_t            seg,
    input  wire logic                           out_ready,
    output logic                                seg_taken,
    output logic                                out_valid,
    output logic [rsbd_pkg::CODE_W-1:0]         slope_code,
    output logic [rsbd_pkg::SAMPLE_W-1:0]       intensity
);
    import rsbd_pkg::*;

    logic [SAMPLE_W-1:0] best_score_reg, best_score_next;
    logic [CODE_W-1:0]   best_code_reg, best_code_next;
    logic [CNT_W-1:0]    slope_cnt_reg, slope_cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]   code_out_reg, code_out_next;
    logic [SAMPLE_W-1:0] score_out_reg, score_out_next;

    logic                out_free;
    logic [SAMPLE_W-1:0] score;
    logic                horizontal;
    logic                better;
    logic [SAMPLE_W-1:0] upd_score;
    logic [CODE_W-1:0]   upd_code;

    assign out_free  = !out_valid_reg || out_ready;
    assign seg_taken = seg_valid && (!seg.tile || out_free);

    assign score      = wrap_abs_diff(seg.h_sum, seg.v_sum);
    assign horizontal = seg.h_sum > seg.v_sum;
    // first slope of a tile always wins, later ones only when strictly higher
    assign better     = (slope_cnt_reg < SLOPES_CNT)
                        && (slope_cnt_reg == '0 || score > best_score_reg);
    assign upd_score  = better ? score : best_score_reg;
    assign upd_code   = better ? (CODE_W'(slope_cnt_reg) + (horizontal ? '0 : SLOPES_OFS))
                               : best_code_reg;

    always_comb
    begin
        best_score_next = best_score_reg;
        best_code_next  = best_code_reg;
        slope_cnt_next  = slope_cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        code_out_next   = code_out_reg;
        score_out_next  = score_out_reg;
        if (seg_taken)
        begin
            if (seg.tile)
            begin
                out_valid_next  = 1'b1;
                code_out_next   = upd_code;
                score_out_next  = upd_score;
                best_score_next = '0;
                best_code_next  = '0;
                slope_cnt_next  = '0;
            end
            else
            begin
                best_score_next = upd_score;
                best_code_next  = upd_code;
                if (slope_cnt_reg != CNT_MAX)
                begin
                    slope_cnt_next = slope_cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_score_reg <= '0;
            best_code_reg  <= '0;
            slope_cnt_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            best_score_reg <= best_score_next;
            best_code_reg  <= best_code_next;
            slope_cnt_reg  <= slope_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_out_reg  <= code_out_next;
        score_out_reg <= score_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign slope_code = code_out_reg;
    assign intensity  = score_out_reg;

    a_tile_restart: assert property (@(posedge clk) disable iff (!rst_n)
        seg_taken && seg.tile |=> slope_cnt_reg == '0 && best_score_reg == '0
                                  && best_code_reg == '0 && out_valid_reg)
        else $error("tile end did not restart the search");

    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !(seg_taken && seg.tile))
        else $error("waiting result overwritten");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        best_code_reg < CODE_W'(2 * SLOPES))
        else $error("best slope code out of range");

endmodule

`default_nettype wire

// ----- rtl/radon_slope_bar_detector.sv -----
// radon slope bar detector
// input channel: in_valid / in_ready with h_sample, v_sample, segment_last
// and tile_last; one sample pair per item, segments in slope order, the host
// supplies samples already at their clamped positions
// output channel: out_valid / out_ready with slope_code and intensity; one
// result per tile, for the item that carries tile_last
// throughput: one item per cycle, sustained, also across segment and tile
// ends, as long as the receiver takes each result; the accepted tile_last
// item goes through the input register, the accumulate stage and the select
// stage, which feeds the result register
// a stalled receiver holds the result register; items keep flowing until a
// segment end needs the full sum register, and in_ready drops only when the
// pipeline behind the input register can not move
// reset clears the sums, the slope counter, the best score and every valid
// flag, so the next item starts a new segment of a new tile
`default_nettype none

module radon_slope_bar_detector (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [rsbd_pkg::SAMPLE_W-1:0] h_sample,
    input  wire logic signed [rsbd_pkg::SAMPLE_W-1:0] v_sample,
    input  wire logic                                 segment_last,
    input  wire logic                                 tile_last,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [rsbd_pkg::CODE_W-1:0]               slope_code,
    output logic [rsbd_pkg::SAMPLE_W-1:0]             intensity
);
    import rsbd_pkg::*;

    logic                in_valid_reg, in_valid_next;
    logic [SAMPLE_W-1:0] h_reg, h_next;
    logic [SAMPLE_W-1:0] v_reg, v_next;
    logic                seg_last_reg, seg_last_next;
    logic                tile_last_reg, tile_last_next;

    logic                item_take;
    logic                seg_valid;
    logic                seg_taken;
    rsbd_seg_t           seg;

    assign in_ready = !in_valid_reg || item_take;

    always_comb
    begin
        in_valid_next  = in_valid_reg && !item_take;
        h_next         = h_reg;
        v_next         = v_reg;
        seg_last_next  = seg_last_reg;
        tile_last_next = tile_last_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next  = 1'b1;
            h_next         = $unsigned(h_sample);
            v_next         = $unsigned(v_sample);
            seg_last_next  = segment_last;
            tile_last_next = tile_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg         <= h_next;
        v_reg         <= v_next;
        seg_last_reg  <= seg_last_next;
        tile_last_reg <= tile_last_next;
    end

    rsbd_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .h_item     (h_reg),
        .v_item     (v_reg),
        .seg_last   (seg_last_reg),
        .tile_last  (tile_last_reg),
        .seg_taken  (seg_taken),
        .item_take  (item_take),
        .seg_valid  (seg_valid),
        .seg        (seg)
    );

    rsbd_select u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .seg_valid  (seg_valid),
        .seg        (seg),
        .out_ready  (out_ready),
        .seg_taken  (seg_taken),
        .out_valid  (out_valid),
        .slope_code (slope_code),
        .intensity  (intensity)
    );

    a_take_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |-> in_valid_reg)
        else $error("item taken from an empty input register");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> in_valid_reg)
        else $error("accepted item lost at the input register");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !item_take |=> in_valid_reg && $stable(h_reg) && $stable(v_reg))
        else $error("stalled item changed in the input register");

endmodule

`default_nettype wire

// ----- bench/radon_slope_bar_detector_tb.sv -----
`timescale 1ns / 100ps

module radon_slope_bar_detector_tb;

    localparam int SW             = rsbd_pkg::SAMPLE_W;
    localparam int CW             = rsbd_pkg::CODE_W;
    localparam int RANDOM_ITEMS   = 850;
    localparam int HOLD_AT_RESULT = 20;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 3000;

    // value styles for a run of samples
    localparam int STYLE_WIDE    = 0;
    localparam int STYLE_NEAR    = 1;
    localparam int STYLE_EXTREME = 2;

    // receiver stall patterns
    localparam int RX_ALWAYS = 0;
    localparam int RX_MOSTLY = 1;
    localparam int RX_RARELY = 2;
    localparam int RX_COIN   = 3;

    typedef struct {
        logic [SW-1:0] h;
        logic [SW-1:0] v;
        logic          seg_end;
        logic          tile_end;
    } sample_pair_t;

    typedef struct {
        logic [CW-1:0] code;
        logic [SW-1:0] level;
    } tile_result_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    logic signed [SW-1:0] h_sample     = '0;
    logic signed [SW-1:0] v_sample     = '0;
    logic                 segment_last = 1'b0;
    logic                 tile_last    = 1'b0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    logic [CW-1:0]        slope_code;
    logic [SW-1:0]        intensity;

    sample_pair_t pairs_to_send[$];
    tile_result_t tile_results[$];
    sample_pair_t next_pair;
    tile_result_t want;

    // running state of the slope scorer
    logic [SW-1:0]            sum_h      = '0;
    logic [SW-1:0]            sum_v      = '0;
    logic [SW-1:0]            last_h     = '0;
    logic [SW-1:0]            last_v     = '0;
    logic                     seg_open   = 1'b0;
    logic [rsbd_pkg::CNT_W-1:0] slope_idx = '0;
    logic [SW-1:0]            top_score  = '0;
    logic [CW-1:0]            top_code   = '0;

    int   error_count  = 0;
    int   pairs_taken  = 0;
    int   tiles_seen   = 0;
    int   total_pairs  = 0;
    int   idle_cycles  = 0;
    logic in_fire      = 1'b0;
    int   burst_left   = 0;
    int   gap_left     = 0;
    int   rx_mode      = RX_ALWAYS;
    int   rx_mode_left = 0;
    int   hold_left    = 0;
    logic hold_done    = 1'b0;

    radon_slope_bar_detector uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .h_sample     (h_sample),
        .v_sample     (v_sample),
        .segment_last (segment_last),
        .tile_last    (tile_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .slope_code   (slope_code),
        .intensity    (intensity)
    );

    always #5 clk = ~clk;

    task automatic flag_error(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic [SW-1:0] wrapped_magnitude(input logic [SW-1:0] a,
                                                        input logic [SW-1:0] b);
        logic signed [SW-1:0] d;
        d = a - b;
        // the most negative difference keeps its pattern
        return (d < 0) ? -d : d;
    endfunction

    task automatic track_pair(input logic [SW-1:0] h, input logic [SW-1:0] v,
                              input logic seg_end, input logic tile_end);
        logic [SW-1:0] score;
        logic          horizontal;
        tile_result_t  res;
        if (seg_open)
        begin
            sum_h = sum_h + wrapped_magnitude(h, last_h);
            sum_v = sum_v + wrapped_magnitude(v, last_v);
        end
        last_h   = h;
        last_v   = v;
        seg_open = 1'b1;
        if (seg_end || tile_end)
        begin
            score      = wrapped_magnitude(sum_h, sum_v);
            horizontal = sum_h > sum_v;
            if (slope_idx < rsbd_pkg::SLOPES_CNT && (slope_idx == '0 || score > top_score))
            begin
                top_score = score;
                top_code  = horizontal ? CW'(slope_idx)
                                       : CW'(slope_idx) + rsbd_pkg::SLOPES_OFS;
            end
            if (slope_idx != rsbd_pkg::CNT_MAX)
            begin
                slope_idx = slope_idx + rsbd_pkg::CNT_W'(1);
            end
            sum_h    = '0;
            sum_v    = '0;
            seg_open = 1'b0;
        end
        if (tile_end)
        begin
            res.code  = top_code;
            res.level = top_score;
            tile_results.push_back(res);
            top_score = '0;
            top_code  = '0;
            slope_idx = '0;
        end
    endtask

    task automatic push_pair(input logic [SW-1:0] h, input logic [SW-1:0] v,
                             input logic seg_end, input logic tile_end);
        sample_pair_t p;
        p.h        = h;
        p.v        = v;
        p.seg_end  = seg_end;
        p.tile_end = tile_end;
        pairs_to_send.push_back(p);
    endtask

    function automatic logic [SW-1:0] pick_value(input int style, input logic [SW-1:0] base);
        logic [SW-1:0] val;
        case (style)
            STYLE_NEAR:
            begin
                val = base + SW'($urandom_range(0, 300));
            end
            STYLE_EXTREME:
            begin
                case ($urandom_range(0, 3))
                    0:       val = 16'h8000;
                    1:       val = 16'h7fff;
                    2:       val = 16'h0000;
                    default: val = 16'hffff;
                endcase
            end
            default:
            begin
                val = SW'($urandom);
            end
        endcase
        return val;
    endfunction

    task automatic queue_tile(input int n_segs, input int max_len);
        int            seg_len;
        int            style_h;
        int            style_v;
        logic [SW-1:0] base_h;
        logic [SW-1:0] base_v;
        logic          last_seg;
        for (int s = 0; s < n_segs; s++)
        begin
            seg_len  = $urandom_range(1, max_len);
            style_h  = $urandom_range(STYLE_WIDE, STYLE_EXTREME);
            style_v  = $urandom_range(STYLE_WIDE, STYLE_EXTREME);
            base_h   = SW'($urandom);
            base_v   = SW'($urandom);
            last_seg = (s == n_segs - 1);
            for (int k = 0; k < seg_len; k++)
            begin
                if (k == seg_len - 1)
                begin
                    // the tile end closes the segment with or without segment_last
                    push_pair(pick_value(style_h, base_h), pick_value(style_v, base_v),
                              last_seg ? 1'($urandom_range(0, 1)) : 1'b1, last_seg);
                end
                else
                begin
                    push_pair(pick_value(style_h, base_h), pick_value(style_v, base_v),
                              1'b0, 1'b0);
                end
            end
        end
    endtask

    // sender: bursts of items with random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire)
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pairs_to_send.size() != 0)
            begin
                next_pair = pairs_to_send.pop_front();
                h_sample     <= next_pair.h;
                v_sample     <= next_pair.v;
                segment_last <= next_pair.seg_end;
                tile_last    <= next_pair.tile_end;
                in_valid     <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: changing stall patterns and one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && tiles_seen == HOLD_AT_RESULT)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      <= $urandom_range(RX_ALWAYS, RX_COIN);
                rx_mode_left <= $urandom_range(20, 200);
            end
            else
            begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                RX_ALWAYS: out_ready <= 1'b1;
                RX_MOSTLY: out_ready <= ($urandom_range(0, 9) < 7);
                RX_RARELY: out_ready <= ($urandom_range(0, 3) == 0);
                default:   out_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // monitor: predict on accepted items, check accepted results
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                track_pair(h_sample, v_sample, segment_last, tile_last);
                pairs_taken <= pairs_taken + 1;
            end
            if (out_valid && out_ready)
            begin
                tiles_seen <= tiles_seen + 1;
                if (tile_results.size() == 0)
                begin
                    flag_error($sformatf("unexpected result code %0d intensity %0d",
                                         slope_code, intensity));
                end
                else
                begin
                    want = tile_results.pop_front();
                    if (slope_code !== want.code)
                    begin
                        flag_error($sformatf("slope_code %0d, want %0d",
                                             slope_code, want.code));
                    end
                    if (intensity !== want.level)
                    begin
                        flag_error($sformatf("intensity %0d, want %0d",
                                             intensity, want.level));
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("FAILURE");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        int n_tiles;
        int directed;

        // single sample tile, tile end without segment end
        push_pair(16'h8000, 16'h7fff, 1'b0, 1'b1);

        // wrap of a sum back to zero, a difference of 32768, a wrapped difference of one
        push_pair(16'h0000, 16'h0000, 1'b0, 1'b0);
        push_pair(16'h8000, 16'h0000, 1'b0, 1'b0);
        push_pair(16'h0000, 16'h0000, 1'b1, 1'b0);
        push_pair(16'h8000, 16'h7fff, 1'b0, 1'b0);
        push_pair(16'h0000, 16'h8000, 1'b1, 1'b0);
        push_pair(16'h0001, 16'h0000, 1'b0, 1'b0);
        push_pair(16'h0001, 16'h0005, 1'b1, 1'b1);

        // equal score later does not replace, equal sums go vertical
        push_pair(16'd100, 16'd0, 1'b0, 1'b0);
        push_pair(16'd110, 16'd0, 1'b1, 1'b0);
        push_pair(16'd0, 16'd0, 1'b0, 1'b0);
        push_pair(16'd0, 16'd10, 1'b1, 1'b0);
        push_pair(16'd0, 16'd0, 1'b0, 1'b0);
        push_pair(16'd7, 16'd7, 1'b0, 1'b1);

        // extremes in both directions, then single-sample segments
        push_pair(16'h7fff, 16'h8000, 1'b0, 1'b0);
        push_pair(16'h8000, 16'h7fff, 1'b1, 1'b0);
        push_pair(16'hffff, 16'h0000, 1'b1, 1'b0);
        push_pair(16'h0000, 16'hffff, 1'b1, 1'b1);

        directed = pairs_to_send.size();
        n_tiles  = 0;
        while (pairs_to_send.size() < directed + RANDOM_ITEMS)
        begin
            // a few tiles run past the slope count
            if (n_tiles == 8)
            begin
                queue_tile(64, 2);
            end
            else if (n_tiles == 35 || $urandom_range(0, 49) == 0)
            begin
                queue_tile($urandom_range(62, 70), 2);
            end
            else
            begin
                queue_tile($urandom_range(1, 8), $urandom_range(1, 6));
            end
            n_tiles++;
        end
        total_pairs = pairs_to_send.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pairs_taken != total_pairs) @(posedge clk);
        while (tile_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rsbd_pkg.sv
rtl/rsbd_accum.sv
rtl/rsbd_select.sv
rtl/radon_slope_bar_detector.sv
bench/radon_slope_bar_detector_tb.sv
